// ----- src/swib_pkg.sv -----
// swib_pkg: shared widths, register indexes, reset values and types
// for the scored-window interval builder; no dependencies
`timescale 1ns / 1ps

package swib_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_BITS_DEF  = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic REG_EXTEND_THRESHOLD = 1'b0;
  localparam logic REG_TRIGGER_CUTOFF   = 1'b1;

  localparam logic [DATA_W-1:0] EXTEND_THRESHOLD_RST = 32'd1;
  localparam logic [DATA_W-1:0] TRIGGER_CUTOFF_RST   = 32'd1;

  typedef struct packed {
    logic [DATA_W-1:0] extend_threshold;
    logic [DATA_W-1:0] trigger_cutoff;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] interval_start;
    logic [DATA_W-1:0] interval_end;
    logic              last_of_run;
  } ivl_t;

  typedef struct packed {
    logic push0;
    logic push1;
    ivl_t word0;
    ivl_t word1;
  } push_t;

endpackage

// ----- src/swib_win_if.sv -----
// swib_win_if: input channel carrying one scored window per word
// depends on swib_pkg
`timescale 1ns / 1ps

interface swib_win_if
  import swib_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] window_start;
  logic [DATA_W-1:0] window_end;
  logic [DATA_W-1:0] window_score;
  logic [DATA_W-1:0] trig_score;
  logic              sequence_end;

  modport source (output valid, window_start, window_end, window_score,
                  trig_score, sequence_end, input ready);
  modport sink (input valid, window_start, window_end, window_score,
                trig_score, sequence_end, output ready);
endinterface

// ----- src/swib_ivl_if.sv -----
// swib_ivl_if: result channel carrying one finished interval per word
// depends on swib_pkg
`timescale 1ns / 1ps

interface swib_ivl_if
  import swib_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] interval_start;
  logic [DATA_W-1:0] interval_end;
  logic              last_of_run;

  modport source (output valid, interval_start, interval_end, last_of_run,
                  input ready);
  modport sink (input valid, interval_start, interval_end, last_of_run,
                output ready);
endinterface

// ----- src/score_window_interval_builder_top.sv -----
// score_window_interval_builder_top: top level of the interval builder
// depends on swib_pkg, swib_win_if, swib_ivl_if, swib_cfg, swib_core, swib_outq
//
//  channel  dir  handshake           words
//  in_ch    in   valid/ready         one scored window
//  out_ch   out  valid/ready         zero to two intervals per window
//  cfg_*    in   apb, pready high    extend_threshold @0, trigger_cutoff @4
//
// one window accepted per cycle while in_ch.ready is high; results are queued
// on acceptance, and a window with two results leaves as two output words
// in_ch.ready drops only when the four-word result queue has under two slots
// reset is synchronous; it clears the open interval and the result queue
`timescale 1ns / 1ps

module score_window_interval_builder_top
  import swib_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swib_win_if.sink              in_ch,
  swib_ivl_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  output logic [DATA_W-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t  cfg;
  push_t push;
  ivl_t  out_word;
  logic  room;
  logic  accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  swib_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  swib_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .window_start  (in_ch.window_start),
    .window_end    (in_ch.window_end),
    .window_score  (in_ch.window_score),
    .trig_score    (in_ch.trig_score),
    .sequence_end  (in_ch.sequence_end),
    .cfg           (cfg),
    .push          (push)
  );

  swib_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.interval_start = out_word.interval_start;
  assign out_ch.interval_end   = out_word.interval_end;
  assign out_ch.last_of_run    = out_word.last_of_run;

endmodule

// ----- src/swib_cfg.sv -----
// swib_cfg: apb-style register file for threshold and cutoff
// depends on swib_pkg
`timescale 1ns / 1ps

module swib_cfg
  import swib_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.extend_threshold <= EXTEND_THRESHOLD_RST;
      cfg_r.trigger_cutoff   <= TRIGGER_CUTOFF_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_EXTEND_THRESHOLD: cfg_r.extend_threshold <= pwdata;
        REG_TRIGGER_CUTOFF:   cfg_r.trigger_cutoff   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXTEND_THRESHOLD: prdata = cfg_r.extend_threshold;
      REG_TRIGGER_CUTOFF:   prdata = cfg_r.trigger_cutoff;
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- src/swib_core.sv -----
// swib_core: open-interval state and per-window decision logic
// depends on swib_pkg; drives up to two result words into swib_outq
`timescale 1ns / 1ps

module swib_core
  import swib_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [DATA_W-1:0] window_start,
  input  logic [DATA_W-1:0] window_end,
  input  logic [DATA_W-1:0] window_score,
  input  logic [DATA_W-1:0] trig_score,
  input  logic              sequence_end,
  input  cfg_t              cfg,
  output push_t             push
);

  logic [POSITION_BITS-1:0] open_start_r, open_start_nxt;
  logic [POSITION_BITS-1:0] open_end_r, open_end_nxt;
  logic [POSITION_BITS-1:0] covered_end_r, covered_end_nxt;
  logic [POSITION_BITS-1:0] ws, we;
  logic [POSITION_BITS-1:0] os_a, oe_a, ce_a;
  logic [POSITION_BITS:0]   ce_p1;
  logic is_open, gap, below_ext, below_cut, close1, flush;

  assign ws        = window_start[POSITION_BITS-1:0];
  assign we        = window_end[POSITION_BITS-1:0];
  assign is_open   = open_end_r > open_start_r;
  assign ce_p1     = {1'b0, covered_end_r} + {{POSITION_BITS{1'b0}}, 1'b1};
  assign gap       = {1'b0, ws} > ce_p1;
  assign below_ext = window_score < cfg.extend_threshold;
  assign below_cut = trig_score < cfg.trigger_cutoff;

  always_comb begin
    close1 = 1'b0;
    os_a   = open_start_r;
    oe_a   = open_end_r;
    ce_a   = covered_end_r;
    if (below_ext) begin
      if (is_open && ws > covered_end_r) begin
        close1 = 1'b1;
        os_a   = '0;
        oe_a   = '0;
        ce_a   = '0;
      end
    end else if (below_cut) begin
      if (is_open) begin
        if (gap) begin
          close1 = 1'b1;
          os_a   = '0;
          oe_a   = '0;
          ce_a   = '0;
        end else begin
          ce_a = we;
        end
      end
    end else begin
      if (is_open) begin
        if (gap) begin
          close1 = 1'b1;
          os_a   = ws;
        end
      end else begin
        os_a = ws;
      end
      oe_a = we;
      ce_a = we;
    end

    flush = sequence_end && (oe_a > os_a);

    if (sequence_end) begin
      open_start_nxt  = '0;
      open_end_nxt    = '0;
      covered_end_nxt = '0;
    end else begin
      open_start_nxt  = os_a;
      open_end_nxt    = oe_a;
      covered_end_nxt = ce_a;
    end
  end

  always_comb begin
    push.push0 = accept && (close1 || flush);
    push.push1 = accept && close1 && flush;
    if (close1) begin
      push.word0.interval_start = DATA_W'(open_start_r);
      push.word0.interval_end   = DATA_W'(open_end_r);
      push.word0.last_of_run    = !flush;
    end else begin
      push.word0.interval_start = DATA_W'(os_a);
      push.word0.interval_end   = DATA_W'(oe_a);
      push.word0.last_of_run    = 1'b1;
    end
    push.word1.interval_start = DATA_W'(os_a);
    push.word1.interval_end   = DATA_W'(oe_a);
    push.word1.last_of_run    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_start_r  <= '0;
      open_end_r    <= '0;
      covered_end_r <= '0;
    end else if (accept) begin
      open_start_r  <= open_start_nxt;
      open_end_r    <= open_end_nxt;
      covered_end_r <= covered_end_nxt;
    end
  end

endmodule

// ----- src/swib_outq.sv -----
// swib_outq: small result queue taking up to two words per cycle
// depends on swib_pkg; feeds out_ch one word per cycle while ready
`timescale 1ns / 1ps

module swib_outq
  import swib_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output ivl_t  out_word
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  ivl_t             mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W:0]   count_r, count_nxt;
  logic [IDX_W-1:0] wr_ptr_p1;
  logic             pop;
  logic [IDX_W:0]   n_push;

  assign out_valid = count_r != '0;
  assign out_word  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = count_r <= (IDX_W+1)'(QUEUE_DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + {{(IDX_W-1){1'b0}}, 1'b1};
  assign n_push    = (IDX_W+1)'(push.push0) + (IDX_W+1)'(push.push1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[IDX_W-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(IDX_W-1){1'b0}}, pop};
    count_nxt  = count_r + n_push - (IDX_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= push.word0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
